@@ hw/rtl/adx_pkg.sv @@
//------------------------------------------------------------------------------
// adx_pkg
// Shared types, constants and the sequencer microcode for the ADX decoder.
//------------------------------------------------------------------------------
`default_nettype none

package adx_pkg;

    localparam int MAX_CHANNELS_DEF = 2;
    localparam int BLOCK_BYTES      = 18;
    localparam int SCALE_BYTES      = 2;
    localparam int PRED_SHIFT       = 12;
    localparam int CFG_IDX_W        = 4;
    localparam int CFG_DATA_W       = 32;
    localparam int ACC_W            = 34;
    localparam int OPND_W           = 17;

    localparam logic signed [ACC_W-1:0] SAT_HI = 34'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_LO = -34'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_A        = 4'd0,
        REG_COEF_B        = 4'd1,
        REG_TOTAL_SAMPLES = 4'd2,
        REG_CHANNEL_COUNT = 4'd3
    } cfg_reg_t;

    typedef logic [2:0] step_t;

    localparam step_t UC_FETCH  = 3'd0;
    localparam step_t UC_MUL_A  = 3'd1;
    localparam step_t UC_MUL_B  = 3'd2;
    localparam step_t UC_MUL_S  = 3'd3;
    localparam step_t UC_COMMIT = 3'd4;

    typedef enum logic [1:0] {
        MS_A_H0,
        MS_B_H1,
        MS_N_SC
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SHADD
    } acc_op_t;

    typedef enum logic [1:0] {
        JC_NEXT,
        JC_NO_DATA,
        JC_NIB_LOOP
    } jump_t;

    typedef struct packed {
        logic     take;
        logic     commit;
        mul_sel_t mul;
        acc_op_t  acc;
        jump_t    jc;
        step_t    target;
    } ucode_t;

    function automatic ucode_t uc_rom(input step_t step);
        ucode_t w;
        w = '{take: 1'b1, commit: 1'b0, mul: MS_A_H0, acc: ACC_HOLD,
              jc: JC_NO_DATA, target: UC_FETCH};
        case (step)
            UC_FETCH:
            begin
                w = '{take: 1'b1, commit: 1'b0, mul: MS_A_H0, acc: ACC_HOLD,
                      jc: JC_NO_DATA, target: UC_FETCH};
            end
            UC_MUL_A:
            begin
                w = '{take: 1'b0, commit: 1'b0, mul: MS_A_H0, acc: ACC_LOAD,
                      jc: JC_NEXT, target: UC_FETCH};
            end
            UC_MUL_B:
            begin
                w = '{take: 1'b0, commit: 1'b0, mul: MS_B_H1, acc: ACC_ADD,
                      jc: JC_NEXT, target: UC_FETCH};
            end
            UC_MUL_S:
            begin
                w = '{take: 1'b0, commit: 1'b0, mul: MS_N_SC, acc: ACC_SHADD,
                      jc: JC_NEXT, target: UC_FETCH};
            end
            UC_COMMIT:
            begin
                w = '{take: 1'b0, commit: 1'b1, mul: MS_A_H0, acc: ACC_HOLD,
                      jc: JC_NIB_LOOP, target: UC_MUL_A};
            end
            default:
            begin
                w = '{take: 1'b1, commit: 1'b0, mul: MS_A_H0, acc: ACC_HOLD,
                      jc: JC_NO_DATA, target: UC_FETCH};
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/adx_byte_if.sv @@
//------------------------------------------------------------------------------
// adx_byte_if
// Byte stream channel: one block-area byte per item.
//------------------------------------------------------------------------------
`default_nettype none

interface adx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/adx_sample_if.sv @@
//------------------------------------------------------------------------------
// adx_sample_if
// Decoded sample channel.
//------------------------------------------------------------------------------
`default_nettype none

interface adx_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_value;
    logic               channel;
    logic [31:0]        sample_index;
    logic               last_of_item;
    logic               end_of_stream;

    modport source (output valid, output sample_value, output channel,
                    output sample_index, output last_of_item,
                    output end_of_stream, input ready);
    modport sink   (input valid, input sample_value, input channel,
                    input sample_index, input last_of_item,
                    input end_of_stream, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/adx_cfg_if.sv @@
//------------------------------------------------------------------------------
// adx_cfg_if
// Register write channel: index and data.
//------------------------------------------------------------------------------
`default_nettype none

interface adx_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [adx_pkg::CFG_IDX_W-1:0] index;
    logic [adx_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/adx_adpcm_decoder.sv @@
//------------------------------------------------------------------------------
// adx_adpcm_decoder
// 4-bit ADX ADPCM decoder: microcoded sequencer around one shared multiplier
// and accumulator, per-channel prediction history in flops.
//------------------------------------------------------------------------------
// channel     dir   payload                                        handshake
// byte_in     in    data_byte[7:0]                                 valid/ready
// sample_out  out   sample_value, channel, sample_index,           valid/ready
//                   last_of_item, end_of_stream
// cfg         in    index[3:0], data[31:0]                         valid/ready
//
// A scale byte needs only the fetch step; a data byte takes fetch plus four
// microcode steps per nibble (two MACs, scale multiply, commit), all on the
// one multiplier. A full output register holds the commit step until taken.
// Reset initialises config, position, scale and history; cfg is always ready.
//------------------------------------------------------------------------------
`default_nettype none

module adx_adpcm_decoder #(
    parameter int MAX_CHANNELS = adx_pkg::MAX_CHANNELS_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    adx_byte_if.sink          byte_in,
    adx_sample_if.source      sample_out,
    adx_cfg_if.sink           cfg
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [1:0] MAX_CH2 = 2'((MAX_CHANNELS > 3) ? 3 : MAX_CHANNELS);

    // configuration
    logic [13:0]        coef_a_reg;
    logic signed [12:0] coef_b_reg;
    logic [31:0]        total_reg;
    logic [1:0]         chan_cnt_reg;

    // sequencer and stream state
    adx_pkg::step_t     pc_reg, pc_next;
    adx_pkg::ucode_t    uc;
    logic [4:0]         pos_reg;
    logic [CH_W-1:0]    cur_reg;
    logic [26:0]        frame_reg;
    logic [15:0]        scale_reg;
    logic [7:0]         byte_reg;
    logic               nib_reg;
    logic signed [adx_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic signed [15:0] hist0_reg [MAX_CHANNELS];
    logic signed [15:0] hist1_reg [MAX_CHANNELS];

    // output register
    logic               out_valid_reg;
    logic signed [15:0] out_value_reg;
    logic               out_chan_reg;
    logic [31:0]        out_index_reg;
    logic               out_last_reg;
    logic               out_eos_reg;

    logic               accept;
    logic               header;
    logic               data_go;
    logic               stall;
    logic               advance;
    logic               load_out;
    logic [1:0]         chans;
    logic [CH_W-1:0]    ch_eff;
    logic               ch_wrap;
    logic               ch_last;
    logic [4:0]         pos_m2;
    logic [31:0]        idx;
    logic               emit;
    logic               idx_last;
    logic signed [3:0]  nib;
    logic signed [adx_pkg::OPND_W-1:0] op_a, op_b;
    logic signed [adx_pkg::ACC_W-1:0]  prod;
    logic signed [15:0] sat;
    logic signed [15:0] h0, h1;

    // channel bookkeeping
    always_comb
    begin
        if (chan_cnt_reg == 2'd0)
            chans = 2'd1;
        else if (chan_cnt_reg > MAX_CH2)
            chans = MAX_CH2;
        else
            chans = chan_cnt_reg;
        ch_eff  = (4'(cur_reg) >= 4'(chans)) ? '0 : cur_reg;
        ch_wrap = (4'(ch_eff) + 4'd1) >= 4'(chans);
        ch_last = 4'(ch_eff) == (4'(chans) - 4'd1);
        h0      = hist0_reg[ch_eff];
        h1      = hist1_reg[ch_eff];
    end

    // handshake and control
    assign uc            = adx_pkg::uc_rom(pc_reg);
    assign byte_in.ready = uc.take;
    assign cfg.ready     = 1'b1;
    assign accept        = byte_in.valid && uc.take;
    assign header        = pos_reg < 5'(adx_pkg::SCALE_BYTES);
    assign data_go       = accept && !header;

    assign pos_m2   = pos_reg - 5'(adx_pkg::SCALE_BYTES);
    assign idx      = {frame_reg, pos_m2[3:0], nib_reg};
    assign emit     = idx < total_reg;
    assign idx_last = idx == (total_reg - 32'd1);

    assign stall    = uc.commit && emit && out_valid_reg && !sample_out.ready;
    assign load_out = uc.commit && !stall && emit;
    assign advance  = (accept && header) || (uc.commit && !stall && nib_reg);

    // next step
    always_comb
    begin
        case (uc.jc)
            adx_pkg::JC_NEXT:     pc_next = pc_reg + 3'd1;
            adx_pkg::JC_NO_DATA:  pc_next = data_go ? pc_reg + 3'd1 : uc.target;
            adx_pkg::JC_NIB_LOOP:
            begin
                if (stall)
                    pc_next = pc_reg;
                else if (!nib_reg)
                    pc_next = uc.target;
                else
                    pc_next = adx_pkg::UC_FETCH;
            end
            default:              pc_next = adx_pkg::UC_FETCH;
        endcase
    end

    // datapath
    always_comb
    begin
        nib = nib_reg ? $signed(byte_reg[3:0]) : $signed(byte_reg[7:4]);
        case (uc.mul)
            adx_pkg::MS_A_H0:
            begin
                op_a = $signed({3'b000, coef_a_reg});
                op_b = 17'(h0);
            end
            adx_pkg::MS_B_H1:
            begin
                op_a = 17'(coef_b_reg);
                op_b = 17'(h1);
            end
            adx_pkg::MS_N_SC:
            begin
                op_a = 17'(nib);
                op_b = $signed({1'b0, scale_reg});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod = op_a * op_b;
        case (uc.acc)
            adx_pkg::ACC_HOLD:  acc_next = acc_reg;
            adx_pkg::ACC_LOAD:  acc_next = prod;
            adx_pkg::ACC_ADD:   acc_next = acc_reg + prod;
            adx_pkg::ACC_SHADD: acc_next = (acc_reg >>> adx_pkg::PRED_SHIFT) + prod;
            default:            acc_next = acc_reg;
        endcase
        if (acc_reg > adx_pkg::SAT_HI)
            sat = 16'sd32767;
        else if (acc_reg < adx_pkg::SAT_LO)
            sat = -16'sd32768;
        else
            sat = acc_reg[15:0];
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (data_go)
            byte_reg <= byte_in.data_byte;
        if (load_out)
        begin
            out_value_reg <= sat;
            out_chan_reg  <= ch_eff[0];
            out_index_reg <= idx;
            out_last_reg  <= nib_reg || idx_last;
            out_eos_reg   <= idx_last && ch_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg    <= '0;
            coef_b_reg    <= '0;
            total_reg     <= '0;
            chan_cnt_reg  <= 2'd2;
            pc_reg        <= adx_pkg::UC_FETCH;
            pos_reg       <= '0;
            cur_reg       <= '0;
            frame_reg     <= '0;
            scale_reg     <= '0;
            nib_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                hist0_reg[i] <= '0;
                hist1_reg[i] <= '0;
            end
        end
        else
        begin
            pc_reg <= pc_next;

            if (cfg.valid)
            begin
                case (adx_pkg::cfg_reg_t'(cfg.index))
                    adx_pkg::REG_COEF_A:        coef_a_reg   <= cfg.data[13:0];
                    adx_pkg::REG_COEF_B:        coef_b_reg   <= $signed(cfg.data[12:0]);
                    adx_pkg::REG_TOTAL_SAMPLES: total_reg    <= cfg.data;
                    adx_pkg::REG_CHANNEL_COUNT: chan_cnt_reg <= cfg.data[1:0];
                    default:                    ;
                endcase
            end

            if (accept && pos_reg == 5'd0)
                scale_reg[15:8] <= byte_in.data_byte;
            if (accept && pos_reg == 5'd1)
                scale_reg[7:0] <= byte_in.data_byte;

            if (data_go)
                nib_reg <= 1'b0;
            else if (uc.commit && !stall)
                nib_reg <= !nib_reg;

            if (uc.commit && !stall)
            begin
                hist0_reg[ch_eff] <= sat;
                hist1_reg[ch_eff] <= h0;
            end

            if (advance)
            begin
                if (pos_reg == 5'(adx_pkg::BLOCK_BYTES - 1))
                begin
                    pos_reg <= '0;
                    if (ch_wrap)
                    begin
                        cur_reg   <= '0;
                        frame_reg <= frame_reg + 27'd1;
                    end
                    else
                        cur_reg <= ch_eff + CH_W'(1);
                end
                else
                begin
                    pos_reg <= pos_reg + 5'd1;
                    cur_reg <= ch_eff;
                end
            end

            out_valid_reg <= load_out || (out_valid_reg && !sample_out.ready);
        end
    end

    assign sample_out.valid         = out_valid_reg;
    assign sample_out.sample_value  = out_value_reg;
    assign sample_out.channel       = out_chan_reg;
    assign sample_out.sample_index  = out_index_reg;
    assign sample_out.last_of_item  = out_last_reg;
    assign sample_out.end_of_stream = out_eos_reg;

endmodule

`default_nettype wire
